/* hdl/usbmidi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// usbmidi_pkg
// code index numbers, result kinds and store control shared by the decoder
// ----------------------------------------------------------------------------
package usbmidi_pkg;

   // header byte values, matched whole (cable 0 only)
   localparam logic [7:0] CIN_SYSEX_CONT  = 8'd4;
   localparam logic [7:0] CIN_SYSEX_END1  = 8'd5;
   localparam logic [7:0] CIN_SYSEX_END2  = 8'd6;
   localparam logic [7:0] CIN_SYSEX_END3  = 8'd7;
   localparam logic [7:0] CIN_NOTE_ON     = 8'd9;
   localparam logic [7:0] CIN_CTRL_CHANGE = 8'd11;
   localparam logic [7:0] CIN_CH_PRESSURE = 8'd13;
   localparam logic [7:0] CIN_PITCH_BEND  = 8'd14;

   // result kinds
   localparam logic [2:0] KIND_NOTE_ON     = 3'd0;
   localparam logic [2:0] KIND_CTRL_CHANGE = 3'd1;
   localparam logic [2:0] KIND_CH_PRESSURE = 3'd2;
   localparam logic [2:0] KIND_PITCH_BEND  = 3'd3;
   localparam logic [2:0] KIND_SYSEX       = 3'd4;

   // packets a message may hold before start/continue beats are dropped
   localparam logic [4:0] COUNT_MAX = 5'd31;

   // bytes streamed per message at most
   localparam int OUT_LIMIT = 64;

   // store port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage : usbmidi_pkg
`default_nettype wire

/* hdl/usbmidi_sysex_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// usbmidi_sysex_store
// sysex byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module usbmidi_sysex_store
   import usbmidi_pkg::*;
#(
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire store_ctl_type ctl,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read register holds its value while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : usbmidi_sysex_store
`default_nettype wire

/* hdl/usb_midi_event_packet_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// usb_midi_event_packet_decoder
// usb-midi event packet decoder for cable 0 with sysex assembly
// ----------------------------------------------------------------------------
// req_ beats carry one 4-byte event packet, rsp_ beats one decoded result
// note-on, control change, channel pressure and pitch bend give one rsp beat
// in the cycle after the req beat
// sysex start/continue packets: the beat, then three byte writes,
// one a cycle through the store write port; a packet arriving with 31 packets
// already stored only marks the message truncated
// sysex end packets write their n carried bytes (n = 1, 2 or 3), then stream
// min(total, SYSEX_BYTES, 64) bytes at one byte per cycle, while the receiver
// does not stall, through the store read port; the store's one write and one
// read port set this pace
// other header values give nothing
// rsp is a registered output; a new req beat is taken while a result waits
// only if that result is not stalled, and only when no sysex packet is in hand
// while the receiver stalls, the stream pauses and the store read register
// holds the next byte
// reset clears the control state, the sysex count and the overflow flag; the
// store is not cleared, only bytes written by the current message are read back
// ----------------------------------------------------------------------------
module usb_midi_event_packet_decoder
   import usbmidi_pkg::*;
#(
   parameter int SYSEX_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_header_byte,
   input  wire logic [7:0] req_midi_byte_a,
   input  wire logic [7:0] req_midi_byte_b,
   input  wire logic [7:0] req_midi_byte_c,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_message_kind,
   output logic [7:0]      rsp_out_byte_a,
   output logic [7:0]      rsp_out_byte_b,
   output logic [7:0]      rsp_out_byte_c,
   output logic [5:0]      rsp_sysex_position,
   output logic            rsp_is_last,
   output logic            rsp_truncated
);

   localparam int AW = $clog2(SYSEX_BYTES);
   // streamed byte limit: smaller of store depth and output limit
   localparam int LIMIT = (SYSEX_BYTES < OUT_LIMIT) ? SYSEX_BYTES : OUT_LIMIT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_STREAM
   } state_type;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   state_type  state_ff,      state_in;
   logic [4:0] count_ff,      count_in;      // packets stored this message
   logic       ovf_ff,        ovf_in;        // some byte was dropped
   logic [7:0] pkt_byte_ff [3];              // latched packet data
   logic [7:0] pkt_byte_in [3];
   logic [1:0] sel_ff,        sel_in;        // byte being written
   logic [1:0] sel_last_ff,   sel_last_in;   // index of last carried byte
   logic       is_end_ff,     is_end_in;     // packet closes the message
   logic [6:0] wpos_ff,       wpos_in;       // write position in message
   logic [6:0] emit_n_ff,     emit_n_in;     // bytes to stream
   logic       trunc_ff,      trunc_in;      // flag for last streamed byte
   logic [6:0] rd_idx_ff,     rd_idx_in;     // next position to read
   logic       data_valid_ff, data_valid_in; // store read register is loaded
   logic [5:0] data_pos_ff,   data_pos_in;
   logic       data_last_ff,  data_last_in;

   logic       rsp_valid_ff,  rsp_valid_in;
   logic [2:0] rsp_kind_ff,   rsp_kind_in;
   logic [7:0] rsp_a_ff,      rsp_a_in;
   logic [7:0] rsp_b_ff,      rsp_b_in;
   logic [7:0] rsp_c_ff,      rsp_c_in;
   logic [5:0] rsp_pos_ff,    rsp_pos_in;
   logic       rsp_last_ff,   rsp_last_in;
   logic       rsp_trunc_ff,  rsp_trunc_in;

   // ---------------------------------------------------------------------
   // store
   // ---------------------------------------------------------------------
   store_ctl_type store_ctl;
   logic [7:0]    store_rd_data;
   logic          wpos_in_range;

   assign wpos_in_range = (32'(wpos_ff) < SYSEX_BYTES);

   usbmidi_sysex_store #(
      .DEPTH (SYSEX_BYTES)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (AW'(wpos_ff)),
      .wr_data (pkt_byte_ff[sel_ff]),
      .rd_addr (AW'(rd_idx_ff)),
      .rd_data (store_rd_data)
   );

   // ---------------------------------------------------------------------
   // handshake terms
   // ---------------------------------------------------------------------
   logic rsp_free;   // output register can take a new result this cycle
   logic req_take;
   logic load_out;   // store byte moves into the output register
   logic issue;      // read of the next streamed position
   logic stream_done;
   logic [6:0] total;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // only idle takes packets; a stalled result blocks channel messages too
   assign req_stall = (state_ff != ST_IDLE) || !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign load_out    = data_valid_ff && rsp_free;
   assign issue       = (state_ff == ST_STREAM) && (rd_idx_ff != emit_n_ff)
                        && (!data_valid_ff || load_out);
   assign stream_done = (state_ff == ST_STREAM) && (rd_idx_ff == emit_n_ff)
                        && (!data_valid_ff || load_out);

   assign store_ctl.wr_en = (state_ff == ST_WRITE) && wpos_in_range;
   assign store_ctl.rd_en = issue;

   assign total = wpos_ff + 7'd1;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      pkt_byte_in   = pkt_byte_ff;
      sel_in        = sel_ff;
      sel_last_in   = sel_last_ff;
      is_end_in     = is_end_ff;
      wpos_in       = wpos_ff;
      emit_n_in     = emit_n_ff;
      trunc_in      = trunc_ff;
      rd_idx_in     = rd_idx_ff;
      data_pos_in   = data_pos_ff;
      data_last_in  = data_last_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_c_in      = rsp_c_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_trunc_in  = rsp_trunc_ff;

      // store read register: set by a read, cleared when moved out
      data_valid_in = issue || (data_valid_ff && !load_out);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_header_byte) inside
                  CIN_NOTE_ON, CIN_CTRL_CHANGE, CIN_CH_PRESSURE, CIN_PITCH_BEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_a_in     = req_midi_byte_a;
                     rsp_b_in     = req_midi_byte_b;
                     rsp_c_in     = req_midi_byte_c;
                     rsp_pos_in   = 6'd0;
                     rsp_last_in  = 1'b1;
                     rsp_trunc_in = 1'b0;
                     unique case (req_header_byte)
                        CIN_NOTE_ON:     rsp_kind_in = KIND_NOTE_ON;
                        CIN_CTRL_CHANGE: rsp_kind_in = KIND_CTRL_CHANGE;
                        CIN_CH_PRESSURE: begin
                           rsp_kind_in = KIND_CH_PRESSURE;
                           rsp_c_in    = 8'd0;
                        end
                        default:         rsp_kind_in = KIND_PITCH_BEND;
                     endcase
                  end
                  CIN_SYSEX_CONT: begin
                     if (count_ff == COUNT_MAX) begin
                        // whole packet dropped
                        ovf_in = 1'b1;
                     end else begin
                        pkt_byte_in = '{req_midi_byte_a, req_midi_byte_b,
                                        req_midi_byte_c};
                        sel_in      = 2'd0;
                        sel_last_in = 2'd2;
                        is_end_in   = 1'b0;
                        wpos_in     = 7'({count_ff, 1'b0}) + 7'(count_ff);
                        state_in    = ST_WRITE;
                     end
                  end
                  CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
                     pkt_byte_in = '{req_midi_byte_a, req_midi_byte_b,
                                     req_midi_byte_c};
                     sel_in      = 2'd0;
                     // low bits of the end code give the carried byte count
                     sel_last_in = req_header_byte[1:0] - 2'd1;
                     is_end_in   = 1'b1;
                     wpos_in     = 7'({count_ff, 1'b0}) + 7'(count_ff);
                     state_in    = ST_WRITE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WRITE: begin
            // one byte a cycle; out-of-range bytes only mark the message
            if (!wpos_in_range) begin
               ovf_in = 1'b1;
            end
            wpos_in = wpos_ff + 7'd1;
            sel_in  = sel_ff + 2'd1;
            if (sel_ff == sel_last_ff) begin
               if (is_end_ff) begin
                  emit_n_in = (total > 7'(LIMIT)) ? 7'(LIMIT) : total;
                  trunc_in  = ovf_ff || !wpos_in_range || (total > 7'(LIMIT));
                  rd_idx_in = 7'd0;
                  state_in  = ST_STREAM;
               end else begin
                  count_in = count_ff + 5'd1;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_STREAM: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + 7'd1;
               data_pos_in  = rd_idx_ff[5:0];
               data_last_in = (rd_idx_ff + 7'd1 == emit_n_ff);
            end
            if (stream_done) begin
               // message closed
               count_in = 5'd0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_SYSEX;
         rsp_a_in     = store_rd_data;
         rsp_b_in     = 8'd0;
         rsp_c_in     = 8'd0;
         rsp_pos_in   = data_pos_ff;
         rsp_last_in  = data_last_ff;
         rsp_trunc_in = data_last_ff && trunc_ff;
      end
   end

   // ---------------------------------------------------------------------
   // state and registered outputs
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= 5'd0;
         ovf_ff        <= 1'b0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pkt_byte_ff  <= pkt_byte_in;
      sel_ff       <= sel_in;
      sel_last_ff  <= sel_last_in;
      is_end_ff    <= is_end_in;
      wpos_ff      <= wpos_in;
      emit_n_ff    <= emit_n_in;
      trunc_ff     <= trunc_in;
      rd_idx_ff    <= rd_idx_in;
      data_pos_ff  <= data_pos_in;
      data_last_ff <= data_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_message_kind   = rsp_kind_ff;
   assign rsp_out_byte_a     = rsp_a_ff;
   assign rsp_out_byte_b     = rsp_b_ff;
   assign rsp_out_byte_c     = rsp_c_ff;
   assign rsp_sysex_position = rsp_pos_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_truncated      = rsp_trunc_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // store is never written and read in the same cycle
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(store_ctl.wr_en && store_ctl.rd_en))
      else $error("store written and read in one cycle");

   // reads stay within the streamed length
   a_read_in_range : assert property (@(posedge clock) disable iff (reset)
      store_ctl.rd_en |-> (rd_idx_ff < emit_n_ff))
      else $error("store read beyond streamed length");

   // a loaded read register only exists while streaming
   a_data_in_stream : assert property (@(posedge clock) disable iff (reset)
      data_valid_ff |-> (state_ff == ST_STREAM))
      else $error("store byte pending outside stream");

   // a closed message leaves no count or overflow behind
   a_stream_close : assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_STREAM && state_ff == ST_IDLE)
      |-> (count_ff == 5'd0 && !ovf_ff))
      else $error("sysex state not cleared after stream");

   // last byte of a stream carries position emit_n - 1
   a_last_position : assert property (@(posedge clock) disable iff (reset)
      load_out && data_last_ff |-> (7'(data_pos_ff) + 7'd1 == emit_n_ff))
      else $error("last sysex byte at wrong position");

endmodule : usb_midi_event_packet_decoder
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the usb-midi event packet decoder
// ----------------------------------------------------------------------------
// packets go in as req beats through one send task
// a shadow of the sysex store predicts every rsp beat when a packet is taken
// the rsp checker pops the predictions in order and compares each field
// named tests: channel messages, ignored headers, short sysex, store boundary
// and count saturation, then a long random run of mostly well-formed sysex
// the sender idles in bursts, the receiver stalls in runs
// ----------------------------------------------------------------------------
module tb;
   import usbmidi_pkg::*;

   localparam int SYSEX_BYTES  = 64;
   localparam int RANDOM_ITEMS = 210;
   localparam int DRAIN_CYCLES = 100;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [5:0] position;
      logic       last;
      logic       trunc;
   } decoded_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_header_byte = 8'd0;
   logic [7:0] req_midi_byte_a = 8'd0;
   logic [7:0] req_midi_byte_b = 8'd0;
   logic [7:0] req_midi_byte_c = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_message_kind;
   logic [7:0] rsp_out_byte_a;
   logic [7:0] rsp_out_byte_b;
   logic [7:0] rsp_out_byte_c;
   logic [5:0] rsp_sysex_position;
   logic       rsp_is_last;
   logic       rsp_truncated;

   // results predicted but not yet seen, oldest first
   decoded_result_type pending_results[$];

   // shadow of the decoder's sysex state
   logic [7:0] sysex_shadow [SYSEX_BYTES];
   logic [4:0] sysex_packets = 5'd0;
   logic       sysex_dropped = 1'b0;

   int error_count = 0;
   int cycle_count = 0;

   // sender and receiver idling controls
   int gap_max   = 0;   // 0: back-to-back beats
   int burst_left = 0;
   int stall_max = 0;   // 0: never stall
   int run_left  = 0;

   usb_midi_event_packet_decoder #(
      .SYSEX_BYTES(SYSEX_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_header_byte    (req_header_byte),
      .req_midi_byte_a    (req_midi_byte_a),
      .req_midi_byte_b    (req_midi_byte_b),
      .req_midi_byte_c    (req_midi_byte_c),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_message_kind   (rsp_message_kind),
      .rsp_out_byte_a     (rsp_out_byte_a),
      .rsp_out_byte_b     (rsp_out_byte_b),
      .rsp_out_byte_c     (rsp_out_byte_c),
      .rsp_sysex_position (rsp_sysex_position),
      .rsp_is_last        (rsp_is_last),
      .rsp_truncated      (rsp_truncated)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor: update the shadow state for one packet, queue its results
   // ------------------------------------------------------------------------
   task automatic push_result(input logic [2:0] kind, input logic [7:0] a,
                              input logic [7:0] b, input logic [7:0] c,
                              input int position, input logic last,
                              input logic trunc);
      decoded_result_type r;
      r.kind     = kind;
      r.byte_a   = a;
      r.byte_b   = b;
      r.byte_c   = c;
      r.position = position[5:0];
      r.last     = last;
      r.trunc    = trunc;
      pending_results.push_back(r);
   endtask

   task automatic predict_packet(input logic [7:0] hdr, input logic [7:0] a,
                                 input logic [7:0] b, input logic [7:0] c);
      logic [7:0] data [3];
      int         base;
      int         carried;
      int         total;
      int         streamed;
      logic       trunc;
      data[0] = a;
      data[1] = b;
      data[2] = c;
      base    = int'(sysex_packets) * 3;
      carried = 0;
      case (hdr)
         CIN_NOTE_ON:     push_result(KIND_NOTE_ON, a, b, c, 0, 1'b1, 1'b0);
         CIN_CTRL_CHANGE: push_result(KIND_CTRL_CHANGE, a, b, c, 0, 1'b1, 1'b0);
         CIN_CH_PRESSURE: push_result(KIND_CH_PRESSURE, a, b, 8'd0, 0, 1'b1, 1'b0);
         CIN_PITCH_BEND:  push_result(KIND_PITCH_BEND, a, b, c, 0, 1'b1, 1'b0);
         CIN_SYSEX_CONT: begin
            // a full packet count drops the whole packet
            if (sysex_packets >= COUNT_MAX) begin
               sysex_dropped = 1'b1;
            end else begin
               carried = 3;
               sysex_packets = sysex_packets + 5'd1;
            end
         end
         CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
            carried = int'(hdr - CIN_SYSEX_END1) + 1;
         end
         default: ;
      endcase

      // bytes beyond the store are lost and mark the message
      for (int i = 0; i < carried; i++) begin
         if (base + i < SYSEX_BYTES) sysex_shadow[base + i] = data[i];
         else sysex_dropped = 1'b1;
      end

      if (hdr == CIN_SYSEX_END1 || hdr == CIN_SYSEX_END2 || hdr == CIN_SYSEX_END3) begin
         total    = base + carried;
         streamed = total;
         if (streamed > SYSEX_BYTES) streamed = SYSEX_BYTES;
         if (streamed > OUT_LIMIT) streamed = OUT_LIMIT;
         trunc = sysex_dropped || (total > streamed);
         for (int i = 0; i < streamed; i++) begin
            push_result(KIND_SYSEX, sysex_shadow[i], 8'd0, 8'd0, i,
                        i == streamed - 1, (i == streamed - 1) && trunc);
         end
         sysex_packets = 5'd0;
         sysex_dropped = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // sender: one req beat, with burst gaps in front when due
   // ------------------------------------------------------------------------
   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] a,
                              input logic [7:0] b, input logic [7:0] c);
      int gap;
      if (gap_max > 0 && burst_left == 0) begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid       <= 1'b1;
      req_header_byte <= hdr;
      req_midi_byte_a <= a;
      req_midi_byte_b <= b;
      req_midi_byte_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packet(hdr, a, b, c);
   endtask

   task automatic set_traffic(input int gaps, input int stalls);
      gap_max   = gaps;
      stall_max = stalls;
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // receiver: stalls in runs, checks every rsp beat taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      decoded_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected rsp beat kind %0d byte %0h pos %0d",
                        $time, rsp_message_kind, rsp_out_byte_a,
                        rsp_sysex_position);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_message_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d",
                           $time, want.kind, rsp_message_kind);
                  error_count++;
               end
               if (rsp_out_byte_a !== want.byte_a) begin
                  $display("%0t: byte a expected %0h actual %0h",
                           $time, want.byte_a, rsp_out_byte_a);
                  error_count++;
               end
               if (rsp_out_byte_b !== want.byte_b) begin
                  $display("%0t: byte b expected %0h actual %0h",
                           $time, want.byte_b, rsp_out_byte_b);
                  error_count++;
               end
               if (rsp_out_byte_c !== want.byte_c) begin
                  $display("%0t: byte c expected %0h actual %0h",
                           $time, want.byte_c, rsp_out_byte_c);
                  error_count++;
               end
               if (rsp_sysex_position !== want.position) begin
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_sysex_position);
                  error_count++;
               end
               if (rsp_is_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_is_last);
                  error_count++;
               end
               if (rsp_truncated !== want.trunc) begin
                  $display("%0t: truncated expected %0b actual %0b",
                           $time, want.trunc, rsp_truncated);
                  error_count++;
               end
            end
         end

         // stall pattern: free runs alternate with stall runs
         if (run_left != 0) begin
            run_left--;
         end else if (rsp_stall || stall_max == 0) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 9);
         end else begin
            rsp_stall <= 1'b1;
            run_left = $urandom_range(0, stall_max - 1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // each channel message with the data bytes at their extremes
   task automatic test_channel_messages();
      set_traffic(0, 0);
      send_packet(CIN_NOTE_ON, 8'h00, 8'h00, 8'h00);
      send_packet(CIN_NOTE_ON, 8'hff, 8'hff, 8'hff);
      send_packet(CIN_CTRL_CHANGE, 8'hb3, 8'h00, 8'hff);
      send_packet(CIN_CH_PRESSURE, 8'hd0, 8'h7f, 8'hff);  // third byte must read 0
      send_packet(CIN_PITCH_BEND, 8'he5, 8'hff, 8'h00);
   endtask

   // cable numbers other than 0 and unused codes give nothing
   task automatic test_ignored_headers();
      set_traffic(3, 2);
      send_packet(8'h00, 8'hff, 8'hff, 8'hff);
      send_packet(8'h19, 8'h90, 8'h40, 8'h7f);
      send_packet(8'hf4, 8'h01, 8'h02, 8'h03);        // continue on cable 15
      send_packet(8'hff, 8'h00, 8'h00, 8'h00);
      send_packet(8'h08, 8'h80, 8'h40, 8'h00);
      send_packet(CIN_NOTE_ON, 8'h90, 8'h3c, 8'h64);  // proves nothing stuck
   endtask

   // end without start and a short message, padding bytes ignored
   task automatic test_short_sysex();
      set_traffic(2, 4);
      send_packet(CIN_SYSEX_END1, 8'hf7, 8'hee, 8'hdd);
      send_packet(CIN_SYSEX_END2, 8'hf0, 8'hf7, 8'hcc);
      send_packet(CIN_SYSEX_END3, 8'hf0, 8'h7e, 8'hf7);
      send_packet(CIN_SYSEX_CONT, 8'hf0, 8'h00, 8'hff);
      send_packet(CIN_SYSEX_CONT, 8'h55, 8'haa, 8'h01);
      send_packet(CIN_CTRL_CHANGE, 8'hb0, 8'h07, 8'h64);  // mid-message channel beat
      send_packet(CIN_SYSEX_END2, 8'h80, 8'hf7, 8'hff);
   endtask

   // exactly a full store, then one byte over it
   task automatic test_store_boundary();
      set_traffic(0, 6);
      for (int i = 0; i < 21; i++)
         send_packet(CIN_SYSEX_CONT, any_byte(), any_byte(), any_byte());
      send_packet(CIN_SYSEX_END1, 8'hf7, any_byte(), any_byte());
      for (int i = 0; i < 21; i++)
         send_packet(CIN_SYSEX_CONT, any_byte(), any_byte(), any_byte());
      send_packet(CIN_SYSEX_END2, any_byte(), 8'hf7, any_byte());
   endtask

   // continue packets past the saturated count are dropped whole
   task automatic test_count_saturation();
      set_traffic(1, 3);
      for (int i = 0; i < 34; i++)
         send_packet(CIN_SYSEX_CONT, any_byte(), any_byte(), any_byte());
      send_packet(CIN_SYSEX_END3, any_byte(), any_byte(), 8'hf7);
      // next message starts clean
      send_packet(CIN_SYSEX_END1, 8'hf7, 8'h00, 8'h00);
   endtask

   // mostly well-formed sysex messages, with channel beats and noise mixed in
   task automatic test_random_traffic(input int items);
      int sent;
      int pick;
      int packets;
      logic [7:0] hdr;
      sent = 0;
      while (sent < items) begin
         // change the idling pattern every so often, with quiet stretches
         if (sent % 100 < 4) begin
            case ($urandom_range(0, 3))
               0: set_traffic(0, 0);
               1: set_traffic(2, 3);
               2: set_traffic(8, 12);
               default: set_traffic(4, 1);
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            case ($urandom_range(0, 9))
               7, 8: packets = $urandom_range(7, 22);
               9: packets = $urandom_range(20, 35);
               default: packets = $urandom_range(0, 6);
            endcase
            for (int i = 0; i < packets; i++)
               send_packet(CIN_SYSEX_CONT, any_byte(), any_byte(), any_byte());
            case ($urandom_range(0, 2))
               0: hdr = CIN_SYSEX_END1;
               1: hdr = CIN_SYSEX_END2;
               default: hdr = CIN_SYSEX_END3;
            endcase
            send_packet(hdr, any_byte(), any_byte(), any_byte());
            sent += packets + 1;
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0: hdr = CIN_NOTE_ON;
               1: hdr = CIN_CTRL_CHANGE;
               2: hdr = CIN_CH_PRESSURE;
               default: hdr = CIN_PITCH_BEND;
            endcase
            send_packet(hdr, any_byte(), any_byte(), any_byte());
            sent++;
         end else begin
            // noise: any header at all, broken sequences among them
            hdr = any_byte();
            send_packet(hdr, any_byte(), any_byte(), any_byte());
            if (hdr inside {CIN_SYSEX_CONT, CIN_SYSEX_END1, CIN_SYSEX_END2,
                            CIN_SYSEX_END3, CIN_NOTE_ON, CIN_CTRL_CHANGE,
                            CIN_CH_PRESSURE, CIN_PITCH_BEND})
               sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_channel_messages();
      test_ignored_headers();
      test_short_sysex();
      test_store_boundary();
      test_count_saturation();
      test_random_traffic(RANDOM_ITEMS);

      req_valid <= 1'b0;
      // let the receiver drain, then watch for stray beats
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
